FILE: rtl/dpl_pkg.sv
// Shared constants, types and a helper function for the depth-pixel to labelled-point block.
package dpl_pkg;

	localparam int unsigned PIX_W    = 12;
	localparam int unsigned DEPTH_W  = 16;
	localparam int unsigned MASK_W   = 24;
	localparam int unsigned COORD_W  = 24;
	localparam int unsigned CENTER_W = 16;
	localparam int unsigned INV_W    = 24;
	localparam int unsigned STEP_W   = 5;
	localparam int unsigned CLASS_W  = 8;
	localparam int unsigned EXCL_W   = 64;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	// products: |offset| * depth, then times 1/f
	localparam int unsigned PROD1_W = CENTER_W + DEPTH_W;
	localparam int unsigned PROD2_W = PROD1_W + INV_W;
	localparam int unsigned FRAC_W  = 28;
	localparam int unsigned Q_W     = PROD2_W + 1 - FRAC_W;

	// mask window, half-open ranges
	localparam logic [PIX_W:0] WINDOW_COL_START = 13'd0;
	localparam logic [PIX_W:0] WINDOW_COL_END   = 13'd848;
	localparam logic [PIX_W:0] WINDOW_ROW_START = 13'd28;
	localparam logic [PIX_W:0] WINDOW_ROW_END   = 13'd452;

	localparam logic [DEPTH_W-1:0]  RST_MAX_DIST   = 16'd4000;
	localparam logic [STEP_W-1:0]   RST_STEP       = 5'd2;
	localparam logic [CENTER_W-1:0] RST_CENTER_COL = 16'd6784;
	localparam logic [CENTER_W-1:0] RST_CENTER_ROW = 16'd3840;
	localparam logic [INV_W-1:0]    RST_INV_COL    = 24'd27962;
	localparam logic [INV_W-1:0]    RST_INV_ROW    = 24'd27962;
	localparam logic [EXCL_W-1:0]   RST_EXCL       = 64'd0;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic [Q_W-1:0] Q_POS_LIMIT = Q_W'(24'h7FFFFF);
	localparam logic [Q_W-1:0] Q_NEG_LIMIT = Q_W'(24'h800000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DIST   = 3'd0,
		REG_STEP       = 3'd1,
		REG_CENTER_COL = 3'd2,
		REG_CENTER_ROW = 3'd3,
		REG_INV_COL    = 3'd4,
		REG_INV_ROW    = 3'd5,
		REG_EXCL       = 3'd6
	} dpl_reg_t;

	// per-stage advance strobes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} dpl_adv_t;

	// four restoring-division steps; remainder stays below the divisor
	function automatic logic [STEP_W-1:0] rem_step4(
		input logic [STEP_W-1:0] r_in,
		input logic [3:0]        bits,
		input logic [STEP_W-1:0] divisor
	);
		logic [STEP_W:0]   t;
		logic [STEP_W-1:0] r;
		r = r_in;
		for (int i = 3; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, divisor})
				t = t - {1'b0, divisor};
			r = t[STEP_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/dpl_if.sv
// Valid/ready channel interfaces for pixel input and point output.
interface dpl_pix_if;
	logic                         valid;
	logic                         ready;
	logic [dpl_pkg::PIX_W-1:0]    col;
	logic [dpl_pkg::PIX_W-1:0]    row;
	logic [dpl_pkg::DEPTH_W-1:0]  depth_mm;
	logic [dpl_pkg::MASK_W-1:0]   mask_value;
	logic                         mode;

	modport source (output valid, col, row, depth_mm, mask_value, mode, input ready);
	modport sink (input valid, col, row, depth_mm, mask_value, mode, output ready);
endinterface

interface dpl_pt_if;
	logic                               valid;
	logic                               ready;
	logic signed [dpl_pkg::COORD_W-1:0] x_mm;
	logic signed [dpl_pkg::COORD_W-1:0] y_mm;
	logic [dpl_pkg::DEPTH_W-1:0]        z_mm;
	logic [dpl_pkg::MASK_W-1:0]         label;
	logic                               label_is_color;

	modport source (output valid, x_mm, y_mm, z_mm, label, label_is_color, input ready);
	modport sink (input valid, x_mm, y_mm, z_mm, label, label_is_color, output ready);
endinterface

FILE: rtl/dpl_axis.sv
// Four-stage back-projection of one axis: offset, two multiplies, round and saturate.
module dpl_axis (
	input  logic                                clk,
	input  dpl_pkg::dpl_adv_t                   adv,
	input  logic [dpl_pkg::PIX_W-1:0]           pix,
	input  logic [dpl_pkg::CENTER_W-1:0]        center,
	input  logic [dpl_pkg::DEPTH_W-1:0]         depth,
	input  logic [dpl_pkg::INV_W-1:0]           inv,
	output logic signed [dpl_pkg::COORD_W-1:0]  coord
);

	logic [dpl_pkg::CENTER_W-1:0] p16;
	logic                         neg_c;
	logic [dpl_pkg::CENTER_W-1:0] mag_c;

	logic [dpl_pkg::CENTER_W-1:0] mag_s1;
	logic [dpl_pkg::DEPTH_W-1:0]  depth_s1;
	logic                         neg_s1;
	logic [dpl_pkg::PROD1_W-1:0]  prod_s2;
	logic                         neg_s2;
	logic [dpl_pkg::PROD2_W-1:0]  prod_s3;
	logic                         neg_s3;
	logic signed [dpl_pkg::COORD_W-1:0] coord_s4;

	logic [dpl_pkg::PROD2_W:0]   rnd_sum;
	logic [dpl_pkg::Q_W-1:0]     q;
	logic [dpl_pkg::Q_W-1:0]     q_neg;
	logic [dpl_pkg::COORD_W-1:0] coord_c;

	// 1/16-pixel offset magnitude
	assign p16   = {pix, 4'b0000};
	assign neg_c = p16 < center;
	assign mag_c = neg_c ? (center - p16) : (p16 - center);

	// round half away from zero on the magnitude, then saturate
	assign rnd_sum = {1'b0, prod_s3}
	               + ((dpl_pkg::PROD2_W + 1)'(1) << (dpl_pkg::FRAC_W - 1));
	assign q       = rnd_sum[dpl_pkg::PROD2_W:dpl_pkg::FRAC_W];
	assign q_neg   = ~q + dpl_pkg::Q_W'(1);

	always_comb begin
		if (neg_s3) begin
			if (q > dpl_pkg::Q_NEG_LIMIT)
				coord_c = ~dpl_pkg::COORD_MAX;
			else
				coord_c = q_neg[dpl_pkg::COORD_W-1:0];
		end else begin
			if (q > dpl_pkg::Q_POS_LIMIT)
				coord_c = dpl_pkg::COORD_MAX;
			else
				coord_c = q[dpl_pkg::COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			mag_s1   <= mag_c;
			neg_s1   <= neg_c;
			depth_s1 <= depth;
		end
		if (adv.s2) begin
			prod_s2 <= mag_s1 * depth_s1;
			neg_s2  <= neg_s1;
		end
		if (adv.s3) begin
			prod_s3 <= prod_s2 * inv;
			neg_s3  <= neg_s2;
		end
		if (adv.s4)
			coord_s4 <= coord_c;
	end

	assign coord = coord_s4;

endmodule

FILE: rtl/depth_pixel_to_labeled_point_unit.sv
// Top level: depth pixel stream in, labelled 3D point stream out, with register file.
//
// Takes one depth pixel word per clock and returns zero or one point word for it, in
// order. A pixel is dropped when its column or row is not a multiple of the step
// register (0 counts as 1), when it lies outside the fixed window (columns 0..847, rows
// 28..451), when its depth exceeds max_distance_mm, or, in class mode, when its class
// is below 64 and its bit is set in exclude_class_mask. Kept pixels give
// x = (16*col - center_col) * depth * inv_focal_col / 2^28 mm, y likewise from the
// row, rounded half away from zero and saturated to 24 bits; z is the depth and the
// label is the class byte or the whole colour word. Throughput is one word per clock
// with an idle output; a point passes through the four-stage arithmetic path (offset,
// depth multiply, focal multiply, rounding) and then the output register, the first
// stage loading at the accepting edge. The step test runs as a remainder, four
// division steps per stage, alongside the multiplies. Stages only advance into
// empty or moving slots, so a stalled output holds its word while bubbles further
// back still fill. Registers are written through cfg_we/cfg_index/cfg_data, one per
// clock, and are only to be changed while no word is in flight.
module depth_pixel_to_labeled_point_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dpl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dpl_pkg::CFG_DATA_W-1:0]       cfg_data,
	dpl_pix_if.sink                              pix,
	dpl_pt_if.source                             pt
);

	// register file
	logic [dpl_pkg::DEPTH_W-1:0]  max_dist_q;
	logic [dpl_pkg::STEP_W-1:0]   step_q;
	logic [dpl_pkg::CENTER_W-1:0] center_col_q;
	logic [dpl_pkg::CENTER_W-1:0] center_row_q;
	logic [dpl_pkg::INV_W-1:0]    inv_col_q;
	logic [dpl_pkg::INV_W-1:0]    inv_row_q;
	logic [dpl_pkg::EXCL_W-1:0]   excl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q   <= dpl_pkg::RST_MAX_DIST;
			step_q       <= dpl_pkg::RST_STEP;
			center_col_q <= dpl_pkg::RST_CENTER_COL;
			center_row_q <= dpl_pkg::RST_CENTER_ROW;
			inv_col_q    <= dpl_pkg::RST_INV_COL;
			inv_row_q    <= dpl_pkg::RST_INV_ROW;
			excl_q       <= dpl_pkg::RST_EXCL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpl_pkg::REG_MAX_DIST:   max_dist_q   <= cfg_data[dpl_pkg::DEPTH_W-1:0];
				dpl_pkg::REG_STEP:       step_q       <= cfg_data[dpl_pkg::STEP_W-1:0];
				dpl_pkg::REG_CENTER_COL: center_col_q <= cfg_data[dpl_pkg::CENTER_W-1:0];
				dpl_pkg::REG_CENTER_ROW: center_row_q <= cfg_data[dpl_pkg::CENTER_W-1:0];
				dpl_pkg::REG_INV_COL:    inv_col_q    <= cfg_data[dpl_pkg::INV_W-1:0];
				dpl_pkg::REG_INV_ROW:    inv_row_q    <= cfg_data[dpl_pkg::INV_W-1:0];
				dpl_pkg::REG_EXCL:       excl_q       <= cfg_data;
				default: ;  // index past the list: ignored
			endcase
		end
	end

	// a step of 0 behaves as 1
	logic [dpl_pkg::STEP_W-1:0] step_eff;
	assign step_eff = (step_q == '0) ? dpl_pkg::STEP_W'(1) : step_q;

	// flow control: a stage loads when empty or when its word moves on
	dpl_pkg::dpl_adv_t adv;
	logic v1_q, v2_q, v3_q, v4_q, out_v_q;
	logic adv_out;

	assign adv_out = !out_v_q || pt.ready;
	assign adv.s4  = !v4_q || adv_out;
	assign adv.s3  = !v3_q || adv.s4;
	assign adv.s2  = !v2_q || adv.s3;
	assign adv.s1  = !v1_q || adv.s2;
	assign pix.ready = adv.s1;

	// stage 0 checks on the incoming word
	logic [dpl_pkg::PIX_W:0]     col_x, row_x;
	logic                        win_ok, depth_ok, excl_hit, keep_c;
	logic [dpl_pkg::MASK_W-1:0]  label_c;
	logic [dpl_pkg::STEP_W-1:0]  rc_c, rr_c;

	assign col_x   = {1'b0, pix.col};
	assign row_x   = {1'b0, pix.row};
	assign win_ok  = (col_x >= dpl_pkg::WINDOW_COL_START) && (col_x < dpl_pkg::WINDOW_COL_END)
	              && (row_x >= dpl_pkg::WINDOW_ROW_START) && (row_x < dpl_pkg::WINDOW_ROW_END);
	assign depth_ok = pix.depth_mm <= max_dist_q;
	// classes 64 and up are never excluded
	assign excl_hit = !pix.mode && (pix.mask_value[7:6] == 2'b00)
	               && excl_q[pix.mask_value[5:0]];
	assign keep_c  = win_ok && depth_ok && !excl_hit;
	assign label_c = pix.mode ? pix.mask_value
	                          : {{(dpl_pkg::MASK_W-dpl_pkg::CLASS_W){1'b0}},
	                             pix.mask_value[dpl_pkg::CLASS_W-1:0]};

	// step remainder: bits 11..8 here, 7..4 in stage 2, 3..0 in stage 3
	assign rc_c = dpl_pkg::rem_step4('0, pix.col[11:8], step_eff);
	assign rr_c = dpl_pkg::rem_step4('0, pix.row[11:8], step_eff);

	// side-band pipeline
	logic                       keep_s1, keep_s2, keep_s3, keep_s4;
	logic [dpl_pkg::STEP_W-1:0] rc_s1, rr_s1, rc_s2, rr_s2;
	logic [7:0]                 col_lo_s1, row_lo_s1;
	logic [3:0]                 col_lo_s2, row_lo_s2;
	logic [dpl_pkg::DEPTH_W-1:0] z_s1, z_s2, z_s3, z_s4;
	logic [dpl_pkg::MASK_W-1:0]  lab_s1, lab_s2, lab_s3, lab_s4;
	logic                        mode_s1, mode_s2, mode_s3, mode_s4;
	logic [dpl_pkg::STEP_W-1:0]  rc_fin, rr_fin;

	assign rc_fin = dpl_pkg::rem_step4(rc_s2, col_lo_s2, step_eff);
	assign rr_fin = dpl_pkg::rem_step4(rr_s2, row_lo_s2, step_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			v4_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv.s1)  v1_q    <= pix.valid;
			if (adv.s2)  v2_q    <= v1_q;
			if (adv.s3)  v3_q    <= v2_q;
			if (adv.s4)  v4_q    <= v3_q;
			// dropped pixels vanish here
			if (adv_out) out_v_q <= v4_q && keep_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			keep_s1   <= keep_c;
			rc_s1     <= rc_c;
			rr_s1     <= rr_c;
			col_lo_s1 <= pix.col[7:0];
			row_lo_s1 <= pix.row[7:0];
			z_s1      <= pix.depth_mm;
			lab_s1    <= label_c;
			mode_s1   <= pix.mode;
		end
		if (adv.s2) begin
			keep_s2   <= keep_s1;
			rc_s2     <= dpl_pkg::rem_step4(rc_s1, col_lo_s1[7:4], step_eff);
			rr_s2     <= dpl_pkg::rem_step4(rr_s1, row_lo_s1[7:4], step_eff);
			col_lo_s2 <= col_lo_s1[3:0];
			row_lo_s2 <= row_lo_s1[3:0];
			z_s2      <= z_s1;
			lab_s2    <= lab_s1;
			mode_s2   <= mode_s1;
		end
		if (adv.s3) begin
			keep_s3 <= keep_s2 && (rc_fin == '0) && (rr_fin == '0);
			z_s3    <= z_s2;
			lab_s3  <= lab_s2;
			mode_s3 <= mode_s2;
		end
		if (adv.s4) begin
			keep_s4 <= keep_s3;
			z_s4    <= z_s3;
			lab_s4  <= lab_s3;
			mode_s4 <= mode_s3;
		end
	end

	// coordinate datapaths
	logic signed [dpl_pkg::COORD_W-1:0] x_s4, y_s4;

	dpl_axis u_axis_col (
		.clk    (clk),
		.adv    (adv),
		.pix    (pix.col),
		.center (center_col_q),
		.depth  (pix.depth_mm),
		.inv    (inv_col_q),
		.coord  (x_s4)
	);

	dpl_axis u_axis_row (
		.clk    (clk),
		.adv    (adv),
		.pix    (pix.row),
		.center (center_row_q),
		.depth  (pix.depth_mm),
		.inv    (inv_row_q),
		.coord  (y_s4)
	);

	// output register
	logic signed [dpl_pkg::COORD_W-1:0] x_q, y_q;
	logic [dpl_pkg::DEPTH_W-1:0]        z_q;
	logic [dpl_pkg::MASK_W-1:0]         label_q;
	logic                               is_color_q;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			x_q        <= x_s4;
			y_q        <= y_s4;
			z_q        <= z_s4;
			label_q    <= lab_s4;
			is_color_q <= mode_s4;
		end
	end

	assign pt.valid          = out_v_q;
	assign pt.x_mm           = x_q;
	assign pt.y_mm           = y_q;
	assign pt.z_mm           = z_q;
	assign pt.label          = label_q;
	assign pt.label_is_color = is_color_q;

endmodule
